// ===== rtl/feg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// feg_pkg - shared types and constants of the fire effect generator
// Field widths, register codes, decay constants and the heat palette.
// ----------------------------------------------------------------------------
package feg_pkg;

    // Default size of the heat map
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 128;

    // Register file
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int AW_REG_W  = 9;
    localparam int AH_REG_W  = 8;
    localparam int OFFSET_W  = 12;

    localparam int RESET_ACTIVE_WIDTH  = 256;
    localparam int RESET_ACTIVE_HEIGHT = 128;
    localparam int WIDTH_MIN           = 2;
    localparam int HEIGHT_MIN          = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_WIDTH  = 2'd0,
        REG_ACTIVE_HEIGHT = 2'd1,
        REG_X_OFFSET      = 2'd2,
        REG_Y_OFFSET      = 2'd3
    } cfg_reg_t;

    // Payload widths
    localparam int ROLL_W  = 4;
    localparam int COORD_W = 13;
    localparam int HEAT_W  = 8;
    localparam int SUM_W   = 10;

    // Fire rules
    localparam logic [ROLL_W-1:0] IGNITE_ROLL = 4'd9;
    localparam logic [HEAT_W-1:0] DECAY_FLOOR = 8'd28;
    localparam logic [HEAT_W-1:0] FULL_HEAT   = 8'd255;

    // Divide by three as multiply by 683/2048, exact for sums up to 765
    localparam int DIV3_PROD_W = 20;
    localparam int DIV3_MUL    = 683;
    localparam int DIV3_SHIFT  = 11;

    // Per-cell control flags
    typedef struct packed {
        logic bottom;   // bottom row: ignite from the spark roll
        logic left;     // column 0
        logic right;    // last column in use
        logic last;     // top row, last column: frame ends here
    } cell_ctl_t;

    typedef struct packed {
        logic [HEAT_W-1:0] red;
        logic [HEAT_W-1:0] green;
        logic [HEAT_W-1:0] blue;
    } rgb_t;

    // Palette ramp: black-blue, blue-red, red-yellow, yellow-white
    function automatic rgb_t palette(input logic [HEAT_W-1:0] h);
        logic [4:0] i;
        rgb_t       c;
        i       = h[4:0];
        c.red   = 8'd255;
        c.green = 8'd255;
        c.blue  = 8'd0;
        case (h[7:5])
            3'd0:
            begin
                c.red   = 8'd0;
                c.green = 8'd0;
                c.blue  = {2'b00, i, 1'b0};
            end
            3'd1:
            begin
                c.red   = {i, 3'b000};
                c.green = 8'd0;
                c.blue  = 8'd64 - {2'b00, i, 1'b0};
            end
            3'd2:
            begin
                c.green = {i, 3'b000};
            end
            3'd3:
            begin
                c.blue = {1'b0, i, 2'b00};
            end
            3'd4:
            begin
                c.blue = 8'd64 + {1'b0, i, 2'b00};
            end
            3'd5:
            begin
                c.blue = 8'd128 + {1'b0, i, 2'b00};
            end
            3'd6:
            begin
                c.blue = 8'd192 + {3'b000, i};
            end
            default:
            begin
                c.blue = 8'd224 + {3'b000, i};
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/feg_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// feg_ram - generic RAM, one write port and two registered read ports
// A read at the address being written returns the new data.
// ----------------------------------------------------------------------------
module feg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= (we && (waddr == raddr_a)) ? wdata : mem_reg[raddr_a];
            rdata_b_reg <= (we && (waddr == raddr_b)) ? wdata : mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule
`default_nettype wire

// ===== rtl/feg_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// feg_scan - register file, scan counters and heat map addressing
// Walks the cells bottom row first, runs the clearing pass after reset.
// ----------------------------------------------------------------------------
module feg_scan
    import feg_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int COL_W      = $clog2(MAX_WIDTH),
    localparam int RAM_DEPTH  = MAX_HEIGHT * (2 ** COL_W),
    localparam int RAM_ADDR_W = $clog2(RAM_DEPTH)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  take,
    output logic                       clearing,
    output logic      [RAM_ADDR_W-1:0] clear_addr,
    output cell_ctl_t                  ctl,
    output logic      [RAM_ADDR_W-1:0] addr_own,
    output logic      [RAM_ADDR_W-1:0] addr_bl,
    output logic      [RAM_ADDR_W-1:0] addr_bc,
    output logic      [RAM_ADDR_W-1:0] addr_br,
    output logic      [COORD_W-1:0]    screen_x,
    output logic      [COORD_W-1:0]    screen_y
);

    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);

    localparam int WID_RST =
        (RESET_ACTIVE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_ACTIVE_WIDTH;
    localparam int HGT_RST =
        (RESET_ACTIVE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_ACTIVE_HEIGHT;

    localparam logic [COL_W-1:0]      COL_ONE   = COL_W'(1);
    localparam logic [ROW_W-1:0]      ROW_ONE   = ROW_W'(1);
    localparam logic [WCNT_W-1:0]     WCNT_ONE  = WCNT_W'(1);
    localparam logic [HCNT_W-1:0]     HCNT_ONE  = HCNT_W'(1);
    localparam logic [RAM_ADDR_W-1:0] CLEAR_END = RAM_ADDR_W'(RAM_DEPTH - 1);

    // Effective (clamped) geometry and offsets
    logic [WCNT_W-1:0]   wid_reg;
    logic [HCNT_W-1:0]   hgt_reg;
    logic [OFFSET_W-1:0] xoff_reg;
    logic [OFFSET_W-1:0] yoff_reg;

    logic [WCNT_W-1:0]   wid_clamp;
    logic [HCNT_W-1:0]   hgt_clamp;
    logic [AW_REG_W-1:0] aw;
    logic [AH_REG_W-1:0] ah;

    // Scan counters
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] rowc_reg;
    logic [ROW_W-1:0] rowc_next;

    logic                  clearing_reg;
    logic [RAM_ADDR_W-1:0] clear_addr_reg;

    logic              col_wrap;
    logic [COL_W-1:0]  col_cur;
    logic [HCNT_W-1:0] rc1;
    logic [ROW_W-1:0]  rc2;
    logic [ROW_W-1:0]  row_cur;
    logic [ROW_W-1:0]  row_below;
    logic              end_row;
    logic [HCNT_W-1:0] rc_inc;

    // Clamp register writes to the supported geometry
    always_comb
    begin
        aw = cfg_data[AW_REG_W-1:0];
        ah = cfg_data[AH_REG_W-1:0];
        if (int'(aw) < WIDTH_MIN)
        begin
            wid_clamp = WCNT_W'(WIDTH_MIN);
        end
        else if (int'(aw) > MAX_WIDTH)
        begin
            wid_clamp = WCNT_W'(MAX_WIDTH);
        end
        else
        begin
            wid_clamp = WCNT_W'(aw);
        end
        if (int'(ah) < HEIGHT_MIN)
        begin
            hgt_clamp = HCNT_W'(HEIGHT_MIN);
        end
        else if (int'(ah) > MAX_HEIGHT)
        begin
            hgt_clamp = HCNT_W'(MAX_HEIGHT);
        end
        else
        begin
            hgt_clamp = HCNT_W'(ah);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wid_reg  <= WCNT_W'(WID_RST);
            hgt_reg  <= HCNT_W'(HGT_RST);
            xoff_reg <= '0;
            yoff_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ACTIVE_WIDTH:  wid_reg  <= wid_clamp;
                REG_ACTIVE_HEIGHT: hgt_reg  <= hgt_clamp;
                REG_X_OFFSET:      xoff_reg <= cfg_data[OFFSET_W-1:0];
                REG_Y_OFFSET:      yoff_reg <= cfg_data[OFFSET_W-1:0];
                default:           xoff_reg <= xoff_reg;
            endcase
        end
    end

    // Resolve the current cell, folding counters that fall outside the area
    always_comb
    begin
        col_wrap  = (WCNT_W'(col_reg) >= wid_reg);
        col_cur   = col_wrap ? '0 : col_reg;
        rc1       = HCNT_W'(rowc_reg) + (col_wrap ? HCNT_ONE : '0);
        rc2       = (rc1 >= hgt_reg) ? '0 : ROW_W'(rc1);
        row_cur   = ROW_W'(hgt_reg - HCNT_ONE - HCNT_W'(rc2));
        row_below = row_cur + ROW_ONE;

        end_row   = ((WCNT_W'(col_cur) + WCNT_ONE) >= wid_reg);
        rc_inc    = HCNT_W'(rc2) + HCNT_ONE;
        col_next  = end_row ? '0 : (col_cur + COL_ONE);
        if (end_row)
        begin
            rowc_next = (rc_inc >= hgt_reg) ? '0 : ROW_W'(rc_inc);
        end
        else
        begin
            rowc_next = rc2;
        end

        ctl.bottom = (rc2 == '0);
        ctl.left   = (col_cur == '0);
        ctl.right  = (WCNT_W'(col_cur) == (wid_reg - WCNT_ONE));
        ctl.last   = (row_cur == '0) && ctl.right;

        addr_own = RAM_ADDR_W'({row_cur, col_cur});
        addr_bl  = RAM_ADDR_W'({row_below, col_cur - COL_ONE});
        addr_bc  = RAM_ADDR_W'({row_below, col_cur});
        addr_br  = RAM_ADDR_W'({row_below, col_cur + COL_ONE});

        screen_x = COORD_W'(xoff_reg) + COORD_W'(col_cur);
        screen_y = COORD_W'(yoff_reg) + COORD_W'(row_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            rowc_reg <= '0;
        end
        else if (take)
        begin
            col_reg  <= col_next;
            rowc_reg <= rowc_next;
        end
    end

    // Clearing pass: zero every heat cell once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_addr_reg <= clear_addr_reg + RAM_ADDR_W'(1);
            if (clear_addr_reg == CLEAR_END)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign clearing   = clearing_reg;
    assign clear_addr = clear_addr_reg;

`ifndef SYNTHESIS
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && ctl.last |=> (col_reg == '0) && (rowc_reg == '0))
        else $error("scan did not restart at the bottom row after the last cell");

    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(wid_reg) >= WIDTH_MIN) && (int'(wid_reg) <= MAX_WIDTH)
        && (int'(hgt_reg) >= HEIGHT_MIN) && (int'(hgt_reg) <= MAX_HEIGHT))
        else $error("effective geometry outside its clamp range");
`endif

endmodule
`default_nettype wire

// ===== rtl/feg_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// feg_cell - heat update and result stage
// Averages and decays the neighborhood, or ignites a bottom cell from its roll, colors it and holds the result.
// ----------------------------------------------------------------------------
module feg_cell
    import feg_pkg::*;
#(
    parameter int ADDR_W = 15
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire cell_ctl_t           ctl,
    input  wire logic [ROLL_W-1:0]   roll,
    input  wire logic [ADDR_W-1:0]  addr_own,
    input  wire logic [COORD_W-1:0]  sx,
    input  wire logic [COORD_W-1:0]  sy,
    input  wire logic [HEAT_W-1:0]   old_own,
    input  wire logic [HEAT_W-1:0]   below_l,
    input  wire logic [HEAT_W-1:0]   below_c,
    input  wire logic [HEAT_W-1:0]   below_r,
    input  wire logic                out_stall,
    output logic                     free,
    output logic                     wr_en,
    output logic      [ADDR_W-1:0]   wr_addr,
    output logic      [HEAT_W-1:0]   wr_data,
    output logic                     out_valid,
    output logic      [COORD_W-1:0]  out_x,
    output logic      [COORD_W-1:0]  out_y,
    output logic      [HEAT_W-1:0]   out_heat,
    output logic      [HEAT_W-1:0]   out_red,
    output logic      [HEAT_W-1:0]   out_green,
    output logic      [HEAT_W-1:0]   out_blue,
    output logic                     out_last
);

    // Update stage (heat map reads land here)
    logic              s1_valid_reg;
    logic              s1_valid_next;
    cell_ctl_t         s1_ctl_reg;
    logic [ROLL_W-1:0] s1_roll_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [COORD_W-1:0] s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;

    // Result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [HEAT_W-1:0]  out_heat_reg;
    rgb_t               out_rgb_reg;
    logic               out_last_reg;

    logic                   adv;
    logic [SUM_W-1:0]       sum;
    logic [DIV3_PROD_W-1:0] prod3;
    logic [HEAT_W-1:0]      avg;
    logic [HEAT_W-1:0]      heat;

    always_comb
    begin
        adv            = s1_valid_reg && (!out_valid_reg || !out_stall);
        s1_valid_next  = take || (s1_valid_reg && !adv);
        out_valid_next = adv || (out_valid_reg && out_stall);
    end

    // Neighborhood average and decay, or ignition on the bottom row
    always_comb
    begin
        sum = SUM_W'(old_own) + SUM_W'(below_c);
        if (s1_ctl_reg.left)
        begin
            sum = sum + SUM_W'(below_r);
        end
        else if (s1_ctl_reg.right)
        begin
            sum = sum + SUM_W'(below_l);
        end
        else
        begin
            sum = sum + SUM_W'(below_l) + SUM_W'(below_r);
        end
        prod3 = DIV3_PROD_W'(sum) * DIV3_PROD_W'(DIV3_MUL);
        if (s1_ctl_reg.left || s1_ctl_reg.right)
        begin
            avg = HEAT_W'(prod3 >> DIV3_SHIFT);
        end
        else
        begin
            avg = sum[SUM_W-1:2];
        end
        if (s1_ctl_reg.bottom)
        begin
            heat = (s1_roll_reg >= IGNITE_ROLL) ? FULL_HEAT : '0;
        end
        else
        begin
            heat = (avg > DECAY_FLOOR) ? (avg - HEAT_W'(1)) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_ctl_reg  <= ctl;
            s1_roll_reg <= roll;
            s1_addr_reg <= addr_own;
            s1_x_reg    <= sx;
            s1_y_reg    <= sy;
        end
        if (adv)
        begin
            out_x_reg    <= s1_x_reg;
            out_y_reg    <= s1_y_reg;
            out_heat_reg <= heat;
            out_rgb_reg  <= palette(heat);
            out_last_reg <= s1_ctl_reg.last;
        end
    end

    assign free      = !s1_valid_reg || adv;
    assign wr_en     = adv;
    assign wr_addr   = s1_addr_reg;
    assign wr_data   = heat;
    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_heat  = out_heat_reg;
    assign out_red   = out_rgb_reg.red;
    assign out_green = out_rgb_reg.green;
    assign out_blue  = out_rgb_reg.blue;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_decay_below_full: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !s1_ctl_reg.bottom |-> (heat != FULL_HEAT))
        else $error("decayed cell reached full heat");

    a_single_border: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_ctl_reg.left && s1_ctl_reg.right))
        else $error("cell marked as both left and right border");
`endif

endmodule
`default_nettype wire

// ===== rtl/fire_effect_generator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fire_effect_generator_unit - demoscene fire effect over a stored heat map
// One spark request in, one colored pixel request out, one cell per item.
// ----------------------------------------------------------------------------
// Usage:
//   Spark channel: each request carries a 4-bit random roll and drives one
//   cell. Cells go bottom row first, left to right, then each row above.
//   The roll matters on the bottom row only (9 or more ignites the cell).
//   Pixel channel: one request per spark with screen position, new heat,
//   palette color and frame_done on the top row's last cell.
//   A spark is registered in the update stage, then its pixel in the result register.
//   Throughput: one cell per clock unless a stalled pixel holds the flow.
//   Each cell reads four heat values (own, and three below) through two
//   copies of the heat map, each with two read ports, and writes back once.
//   A stalled pixel is held in the result register; the update stage still
//   takes a spark if it is empty, and the spark side stalls once it is full.
//   Reset: the heat map is cleared one cell a cycle, all MAX_HEIGHT times
//   2**ceil(log2(MAX_WIDTH)) cells (32768 at the defaults); spark_stall
//   stays high meanwhile. Registers may be written at any time while idle.
// ----------------------------------------------------------------------------
module fire_effect_generator_unit
    import feg_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // Register write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,

    // Spark requests
    input  wire logic                 spark_valid,
    output logic                      spark_stall,
    input  wire logic [ROLL_W-1:0]    spark_roll,

    // Pixel requests
    output logic                      pixel_valid,
    input  wire logic                 pixel_stall,
    output logic      [COORD_W-1:0]   screen_x,
    output logic      [COORD_W-1:0]   screen_y,
    output logic      [HEAT_W-1:0]    heat,
    output logic      [HEAT_W-1:0]    red,
    output logic      [HEAT_W-1:0]    green,
    output logic      [HEAT_W-1:0]    blue,
    output logic                      frame_done
);

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int RAM_DEPTH  = MAX_HEIGHT * (2 ** COL_W);
    localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);

    logic                  take;
    logic                  clearing;
    logic [RAM_ADDR_W-1:0] clear_addr;
    cell_ctl_t             ctl;
    logic [RAM_ADDR_W-1:0] addr_own;
    logic [RAM_ADDR_W-1:0] addr_bl;
    logic [RAM_ADDR_W-1:0] addr_bc;
    logic [RAM_ADDR_W-1:0] addr_br;
    logic [COORD_W-1:0]    sx;
    logic [COORD_W-1:0]    sy;

    logic                  cell_free;
    logic                  cell_we;
    logic [RAM_ADDR_W-1:0] cell_waddr;
    logic [HEAT_W-1:0]     cell_wdata;

    logic                  ram_we;
    logic [RAM_ADDR_W-1:0] ram_waddr;
    logic [HEAT_W-1:0]     ram_wdata;

    logic [HEAT_W-1:0]     old_own;
    logic [HEAT_W-1:0]     below_l;
    logic [HEAT_W-1:0]     below_c;
    logic [HEAT_W-1:0]     below_r;

    // Hold sparks during the clearing pass and while the update stage is
    // blocked behind a stalled pixel.
    assign spark_stall = clearing || !cell_free;
    assign take        = spark_valid && !spark_stall;

    // The clearing pass owns the write port until it ends; cell updates
    // start only after it.
    assign ram_we    = clearing || cell_we;
    assign ram_waddr = clearing ? clear_addr : cell_waddr;
    assign ram_wdata = clearing ? '0 : cell_wdata;

    feg_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .take       (take),
        .clearing   (clearing),
        .clear_addr (clear_addr),
        .ctl        (ctl),
        .addr_own   (addr_own),
        .addr_bl    (addr_bl),
        .addr_bc    (addr_bc),
        .addr_br    (addr_br),
        .screen_x   (sx),
        .screen_y   (sy)
    );

    // Two identical copies of the heat map: copy A serves the left and right
    // neighbors below, copy B the center below and the cell's own old heat.
    // Reads issue as the spark is taken; a write at the same edge bypasses.
    feg_ram #(
        .WIDTH (HEAT_W),
        .DEPTH (RAM_DEPTH)
    ) u_heat_a (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (take),
        .raddr_a (addr_bl),
        .raddr_b (addr_br),
        .rdata_a (below_l),
        .rdata_b (below_r)
    );

    feg_ram #(
        .WIDTH (HEAT_W),
        .DEPTH (RAM_DEPTH)
    ) u_heat_b (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (take),
        .raddr_a (addr_bc),
        .raddr_b (addr_own),
        .rdata_a (below_c),
        .rdata_b (old_own)
    );

    feg_cell #(
        .ADDR_W (RAM_ADDR_W)
    ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .ctl       (ctl),
        .roll      (spark_roll),
        .addr_own  (addr_own),
        .sx        (sx),
        .sy        (sy),
        .old_own   (old_own),
        .below_l   (below_l),
        .below_c   (below_c),
        .below_r   (below_r),
        .out_stall (pixel_stall),
        .free      (cell_free),
        .wr_en     (cell_we),
        .wr_addr   (cell_waddr),
        .wr_data   (cell_wdata),
        .out_valid (pixel_valid),
        .out_x     (screen_x),
        .out_y     (screen_y),
        .out_heat  (heat),
        .out_red   (red),
        .out_green (green),
        .out_blue  (blue),
        .out_last  (frame_done)
    );

`ifndef SYNTHESIS
    a_no_update_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cell_we |-> !clearing)
        else $error("cell update collided with the clearing pass");
`endif

endmodule
`default_nettype wire

// ===== verif/fire_effect_generator_checker.sv =====
// ----------------------------------------------------------------------------
// fire_effect_generator_checker - pixel predictor and scoreboard
// Mirrors the heat map and counters of the fire effect, predicts one pixel
// per accepted spark request and compares every accepted pixel in order.
// ----------------------------------------------------------------------------
module fire_effect_generator_checker
    import feg_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,

    input  wire logic                 spark_valid,
    input  wire logic                 spark_stall,
    input  wire logic [ROLL_W-1:0]    spark_roll,

    input  wire logic                 pixel_valid,
    input  wire logic                 pixel_stall,
    input  wire logic [COORD_W-1:0]   screen_x,
    input  wire logic [COORD_W-1:0]   screen_y,
    input  wire logic [HEAT_W-1:0]    heat,
    input  wire logic [HEAT_W-1:0]    red,
    input  wire logic [HEAT_W-1:0]    green,
    input  wire logic [HEAT_W-1:0]    blue,
    input  wire logic                 frame_done,

    output int unsigned               pending,
    output int unsigned               mismatches,
    output int unsigned               checked
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [HEAT_W-1:0]  heat;
        rgb_t               color;
        logic               done;
    } pixel_t;

    logic [HEAT_W-1:0]   heat_map [MAX_WIDTH*MAX_HEIGHT];
    int unsigned         col_ctr;
    int unsigned         row_ctr;
    logic [AW_REG_W-1:0] width_reg;
    logic [AH_REG_W-1:0] height_reg;
    logic [OFFSET_W-1:0] x_off;
    logic [OFFSET_W-1:0] y_off;

    pixel_t              pixels_due [$];
    pixel_t              want;
    int unsigned         bad;
    int unsigned         seen;

    // Flame ramp: black to blue, blue to red, red to yellow, yellow to white
    function automatic rgb_t flame_color(input logic [HEAT_W-1:0] h);
        int unsigned i;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        i = h % 32;
        r = 255;
        g = 255;
        b = 0;
        case (h / 32)
            0:
            begin
                r = 0;
                g = 0;
                b = i * 2;
            end
            1:
            begin
                r = i * 8;
                g = 0;
                b = 64 - i * 2;
            end
            2:       g = i * 8;
            3:       b = i * 4;
            4:       b = 64 + i * 4;
            5:       b = 128 + i * 4;
            6:       b = 192 + i;
            default: b = 224 + i;
        endcase
        return '{red: 8'(r), green: 8'(g), blue: 8'(b)};
    endfunction

    // Advance the mirrored fire by one cell and return the pixel it yields
    function automatic pixel_t update_cell(input logic [ROLL_W-1:0] roll);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        int unsigned below;
        int unsigned sum;
        int unsigned hv;
        pixel_t      p;
        w = (width_reg < WIDTH_MIN) ? WIDTH_MIN :
            (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN :
            (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;

        // Counters left beyond a shrunken area wrap to the next row or frame
        if (col_ctr >= w)
        begin
            col_ctr = 0;
            row_ctr++;
        end
        if (row_ctr >= h)
            row_ctr = 0;

        col = col_ctr;
        row = h - 1 - row_ctr;
        if (row_ctr == 0)
            hv = (roll >= IGNITE_ROLL) ? FULL_HEAT : 0;
        else
        begin
            below = (row + 1) * MAX_WIDTH;
            sum = heat_map[row * MAX_WIDTH + col] + heat_map[below + col];
            if (col == 0)
                sum = (sum + heat_map[below + 1]) / 3;
            else if (col == w - 1)
                sum = (sum + heat_map[below + col - 1]) / 3;
            else
                sum = (sum + heat_map[below + col - 1] + heat_map[below + col + 1]) / 4;
            hv = (sum > DECAY_FLOOR) ? sum - 1 : 0;
        end
        heat_map[row * MAX_WIDTH + col] = 8'(hv);

        p.x     = COORD_W'(x_off + col);
        p.y     = COORD_W'(y_off + row);
        p.heat  = 8'(hv);
        p.color = flame_color(8'(hv));
        p.done  = (row == 0) && (col == w - 1);

        col_ctr++;
        if (col_ctr >= w)
        begin
            col_ctr = 0;
            row_ctr++;
            if (row_ctr >= h)
                row_ctr = 0;
        end
        return p;
    endfunction

    task automatic check_field(input string name, input logic [COORD_W-1:0] exp_v,
                               input logic [COORD_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            bad++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_WIDTH * MAX_HEIGHT; c++)
                heat_map[c] = '0;
            col_ctr    = 0;
            row_ctr    = 0;
            width_reg  = AW_REG_W'(RESET_ACTIVE_WIDTH);
            height_reg = AH_REG_W'(RESET_ACTIVE_HEIGHT);
            x_off      = '0;
            y_off      = '0;
            pixels_due.delete();
            bad        = 0;
            seen       = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ACTIVE_WIDTH:  width_reg  = cfg_data[AW_REG_W-1:0];
                    REG_ACTIVE_HEIGHT: height_reg = cfg_data[AH_REG_W-1:0];
                    REG_X_OFFSET:      x_off      = cfg_data[OFFSET_W-1:0];
                    REG_Y_OFFSET:      y_off      = cfg_data[OFFSET_W-1:0];
                    default:           ;
                endcase
            end

            if (spark_valid && !spark_stall)
                pixels_due.push_back(update_cell(spark_roll));

            if (pixel_valid && !pixel_stall)
            begin
                if (pixels_due.size() == 0)
                begin
                    $error("pixel at (%0d, %0d) with no spark request waiting",
                           screen_x, screen_y);
                    bad++;
                end
                else
                begin
                    want = pixels_due.pop_front();
                    check_field("screen_x", want.x, screen_x);
                    check_field("screen_y", want.y, screen_y);
                    check_field("heat", 13'(want.heat), 13'(heat));
                    check_field("red", 13'(want.color.red), 13'(red));
                    check_field("green", 13'(want.color.green), 13'(green));
                    check_field("blue", 13'(want.color.blue), 13'(blue));
                    check_field("frame_done", 13'(want.done), 13'(frame_done));
                    seen++;
                end
            end
        end
        pending    <= pixels_due.size();
        mismatches <= bad;
        checked    <= seen;
    end

endmodule

// ===== verif/fire_effect_generator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// fire_effect_generator_unit_tb - testbench of the fire effect generator
// Drives spark requests through a series of area sizes and offsets, with
// random gaps on the spark side and random stalls on the pixel side, and
// lets a side checker predict and compare every pixel request.
// ----------------------------------------------------------------------------
module fire_effect_generator_unit_tb;
    import feg_pkg::*;

    localparam int SPARK_TARGET    = 1650;
    localparam int QUIET_TAIL_FROM = 1450;
    // Clearing pass plus every spark at its worst gap and stall, many times over
    localparam int CYCLE_LIMIT     = 400000;

    // Opening rolls, first request in the low nibble: a 4x3 area, two frames.
    // Frame one bottom row: 15, 9, 8, 0 (both sides of the ignition threshold);
    // frame two bottom row fully lit so heat climbs into the upper rows.
    localparam logic [24*ROLL_W-1:0] OPENING_ROLLS = 96'h0F76_A5C3_99FF_B4D2_E1F0_089F;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = REG_ACTIVE_WIDTH;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 spark_valid = 1'b0;
    logic [ROLL_W-1:0]    spark_roll  = '0;
    logic                 pixel_stall = 1'b0;

    logic                 spark_stall;
    logic                 pixel_valid;
    logic [COORD_W-1:0]   screen_x;
    logic [COORD_W-1:0]   screen_y;
    logic [HEAT_W-1:0]    heat;
    logic [HEAT_W-1:0]    red;
    logic [HEAT_W-1:0]    green;
    logic [HEAT_W-1:0]    blue;
    logic                 frame_done;

    int unsigned          pending;
    int unsigned          mismatches;
    int unsigned          checked;

    logic                 pacing_on = 1'b1;
    int unsigned          sent      = 0;
    int unsigned          settings  = 0;
    int unsigned          cycles    = 0;

    fire_effect_generator_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .spark_valid (spark_valid),
        .spark_stall (spark_stall),
        .spark_roll  (spark_roll),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .heat        (heat),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .frame_done  (frame_done)
    );

    fire_effect_generator_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .spark_valid (spark_valid),
        .spark_stall (spark_stall),
        .spark_roll  (spark_roll),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .heat        (heat),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .frame_done  (frame_done),
        .pending     (pending),
        .mismatches  (mismatches),
        .checked     (checked)
    );

    always
    begin
        #10 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost pixel ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d pixels still pending", cycles, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Pixel side: random stall bursts between ready stretches
    initial
    begin : pixel_pacing
        int unsigned hold;
        forever
        begin
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (pacing_on && $urandom_range(0, 1) == 0)
            begin
                hold = $urandom_range(1, 14);
                pixel_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                pixel_stall <= 1'b0;
            end
        end
    end

    // Present one spark request and hold it until the block takes it.
    // Valid stays high across back-to-back requests; a gap drops it first.
    task automatic send_spark(input logic [ROLL_W-1:0] roll);
        int unsigned gap;
        if (pacing_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            spark_valid <= 1'b0;
            spark_roll  <= ROLL_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        spark_valid <= 1'b1;
        spark_roll  <= roll;
        @(posedge clk);
        while (spark_stall)
            @(posedge clk);
        sent++;
        // Drop all idling for the tail of the run
        if (sent >= QUIET_TAIL_FROM)
            pacing_on <= 1'b0;
    endtask

    // Hold off sparks and wait until every predicted pixel has drained
    task automatic wait_drained;
        spark_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Write the selected registers back to back, then release the write enable
    task automatic apply_setting(input logic [3:0] which, input logic [CFG_W-1:0] w_val,
                                 input logic [CFG_W-1:0] h_val, input logic [CFG_W-1:0] x_val,
                                 input logic [CFG_W-1:0] y_val);
        if (which[0])
            write_reg(REG_ACTIVE_WIDTH, w_val);
        if (which[1])
            write_reg(REG_ACTIVE_HEIGHT, h_val);
        if (which[2])
            write_reg(REG_X_OFFSET, x_val);
        if (which[3])
            write_reg(REG_Y_OFFSET, y_val);
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial
    begin : stimulus
        int unsigned      burst;
        int unsigned      phase;
        logic [3:0]       which;
        logic [CFG_W-1:0] w_raw;
        logic [CFG_W-1:0] h_raw;
        logic [CFG_W-1:0] xo_raw;
        logic [CFG_W-1:0] yo_raw;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening frames: small area, both offsets at their top value
        apply_setting(4'b1111, 12'd4, 12'd3, 12'hFFF, 12'hFFF);
        for (int i = 0; i < 24; i++)
            send_spark(OPENING_ROLLS[i*ROLL_W +: ROLL_W]);

        phase = 0;
        while (sent < SPARK_TARGET)
        begin
            wait_drained();
            pacing_on <= (sent < QUIET_TAIL_FROM) && ($urandom_range(0, 4) != 0);
            xo_raw = 12'($urandom);
            yo_raw = 12'($urandom);
            case (phase)
                0:
                begin
                    // Width 1 and height 0 after masking: saturate to a 2-wide single row
                    which = 4'b1111;
                    w_raw = 12'h201;
                    h_raw = 12'h100;
                    xo_raw = '0;
                    yo_raw = '0;
                    burst = 40;
                end
                1:
                begin
                    // Oversized area saturates to the full map; largest screen position
                    which = 4'b1111;
                    w_raw = 12'hFFF;
                    h_raw = 12'hFFF;
                    xo_raw = 12'hFFF;
                    yo_raw = 12'hFFF;
                    burst = 150;
                end
                2:
                begin
                    // Full-width single row; counters carry over from the last area
                    which = 4'b0011;
                    w_raw = 12'd256;
                    h_raw = 12'd1;
                    burst = 300;
                end
                3:
                begin
                    // Width 0 saturates to 2; tall area leaves the row count high
                    which = 4'b0011;
                    w_raw = 12'd0;
                    h_raw = 12'd128;
                    burst = 120;
                end
                default:
                begin
                    // Mostly small areas so heat climbs through many frames
                    which = 4'($urandom_range(1, 15));
                    w_raw = 12'($urandom_range(2, 9));
                    h_raw = 12'($urandom_range(1, 10));
                    if ($urandom_range(0, 7) == 0)
                    begin
                        w_raw = 12'($urandom);
                        h_raw = 12'($urandom);
                    end
                    if ($urandom_range(0, 3) == 0)
                        xo_raw = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                    if ($urandom_range(0, 3) == 0)
                        yo_raw = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                    burst = $urandom_range(50, 150);
                end
            endcase
            apply_setting(which, w_raw, h_raw, xo_raw, yo_raw);
            for (int k = 0; k < burst && sent < SPARK_TARGET; k++)
                send_spark(ROLL_W'($urandom_range(0, 15)));
            phase++;
        end

        wait_drained();
        repeat (4) @(posedge clk);

        $display("Drove %0d spark requests under %0d register settings; %0d pixels compared",
                 sent, settings, checked);
        $display("Areas ran from a 2-wide single row to the full 256x128 map, offsets 0 to 4095");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
